[src/swsf_pkg.sv]
`timescale 1ns / 1ps
package swsf_pkg;
   localparam int WINDOW_DEPTH = 32;
   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = 16 + CNT_W;
   localparam int SQ_W = 32 + CNT_W;
   // n*S2 and S1^2 both fit in this width.
   localparam int NUM_W = SQ_W + CNT_W;
   localparam int DEN_W = 2 * CNT_W;
   localparam logic [9:0] RATE_SCALE = 10'd1000;

   typedef struct packed {
      logic load;      // latch the new sample and read the old slot
      logic update;    // write the window and form the squares
      logic mul_num;   // fold the sample into the sums
      logic mul_sq;    // form n*S2 - S1^2
      logic div_start; // start the variance divide
      logic rdiv_start; // start the rate divide
      logic sqrt_start;
      logic finish;    // result register loads
   } swsf_cmd_type;

   typedef struct packed {
      logic div_done;
      logic sqrt_done;
   } swsf_sts_type;
endpackage

[src/swsf_datapath.sv]
`timescale 1ns / 1ps
module swsf_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  swsf_pkg::swsf_cmd_type       cmd,
   output swsf_pkg::swsf_sts_type       sts,
   input  logic [15:0]                  distance,
   input  logic [31:0]                  timestamp,
   output logic [15:0]                  distance_out,
   output logic [31:0]                  timestamp_out,
   output logic [30:0]                  variance,
   output logic [15:0]                  jitter,
   output logic [25:0]                  rate_out
);
   localparam int NW = swsf_pkg::NUM_W;

   logic [15:0] window_mem [swsf_pkg::WINDOW_DEPTH];
   logic [15:0] old_ff;
   logic [15:0] d_ff;
   logic [31:0] t_ff;
   logic [swsf_pkg::PTR_W-1:0] wp_ff;
   logic [swsf_pkg::CNT_W-1:0] cnt_ff;
   logic [swsf_pkg::SUM_W-1:0] sum_ff;
   logic [swsf_pkg::SQ_W-1:0] sq_ff;
   logic [15:0] pd_ff;
   logic [31:0] pt_ff;
   logic have_ff;
   logic full_ff;
   logic [31:0] dsq_ff;
   logic [31:0] osq_ff;
   logic [NW-1:0] num_ff;
   logic rate_ok_ff;
   logic [25:0] rnum_ff;
   logic [31:0] dt_ff;

   // Variance divider: restoring, one quotient bit per cycle.
   logic [NW-1:0] q_ff;
   logic [swsf_pkg::DEN_W:0] rem_ff;
   logic [swsf_pkg::DEN_W-1:0] den_ff;
   logic [6:0] dcnt_ff;
   logic dbusy_ff;
   // Rate divider.
   logic [25:0] rq_ff;
   logic [32:0] rrem_ff;
   logic [4:0] rcnt_ff;
   logic rbusy_ff;
   // Square root: two bits of the radicand per cycle.
   logic [31:0] sv_ff;
   logic [15:0] root_ff;
   logic [17:0] srem_ff;
   logic [4:0] scnt_ff;
   logic sbusy_ff;

   logic [swsf_pkg::DEN_W:0] rem_sh;
   logic [32:0] rrem_sh;
   logic [17:0] srem_sh;
   logic [17:0] strial;
   logic [15:0] diff;

   assign rem_sh = {rem_ff[swsf_pkg::DEN_W-1:0], q_ff[NW-1]};
   assign rrem_sh = {rrem_ff[31:0], rq_ff[25]};
   assign srem_sh = {srem_ff[15:0], sv_ff[31:30]};
   assign strial = {root_ff, 2'b01};
   assign diff = (d_ff >= pd_ff) ? d_ff - pd_ff : pd_ff - d_ff;

   assign sts.div_done = !dbusy_ff && !rbusy_ff;
   assign sts.sqrt_done = !sbusy_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         old_ff <= window_mem[wp_ff];
         d_ff <= distance;
         t_ff <= timestamp;
      end
      if (cmd.update) begin
         window_mem[wp_ff] <= d_ff;
         dsq_ff <= d_ff * d_ff;
         osq_ff <= old_ff * old_ff;
         rnum_ff <= 26'(diff) * 26'(swsf_pkg::RATE_SCALE);
         dt_ff <= t_ff - pt_ff;
         rate_ok_ff <= have_ff && (t_ff > pt_ff);
      end
      if (cmd.mul_sq)
         num_ff <= NW'(cnt_ff) * NW'(sq_ff) - NW'(sum_ff) * NW'(sum_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         cnt_ff <= '0;
         sum_ff <= '0;
         sq_ff <= '0;
         pd_ff <= '0;
         pt_ff <= '0;
         have_ff <= 1'b0;
         full_ff <= 1'b0;
      end else if (cmd.mul_num) begin
         // Runs after update, so squares are ready.
         sum_ff <= full_ff ? sum_ff - swsf_pkg::SUM_W'(old_ff) + swsf_pkg::SUM_W'(d_ff)
                           : sum_ff + swsf_pkg::SUM_W'(d_ff);
         sq_ff <= full_ff ? sq_ff - swsf_pkg::SQ_W'(osq_ff) + swsf_pkg::SQ_W'(dsq_ff)
                          : sq_ff + swsf_pkg::SQ_W'(dsq_ff);
         if (!full_ff)
            cnt_ff <= cnt_ff + 1'b1;
         full_ff <= full_ff || (cnt_ff == swsf_pkg::CNT_W'(swsf_pkg::WINDOW_DEPTH - 1));
         wp_ff <= (wp_ff == swsf_pkg::PTR_W'(swsf_pkg::WINDOW_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         pd_ff <= d_ff;
         pt_ff <= t_ff;
         have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         rbusy_ff <= 1'b0;
         sbusy_ff <= 1'b0;
      end else begin
         if (cmd.div_start) begin
            q_ff <= (cnt_ff >= swsf_pkg::CNT_W'(2)) ? num_ff : '0;
            rem_ff <= '0;
            den_ff <= swsf_pkg::DEN_W'(cnt_ff) * swsf_pkg::DEN_W'(cnt_ff);
            dcnt_ff <= 7'(NW);
            dbusy_ff <= (cnt_ff >= swsf_pkg::CNT_W'(2));
         end else if (dbusy_ff) begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_ff <= rem_sh - {1'b0, den_ff};
               q_ff <= {q_ff[NW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               q_ff <= {q_ff[NW-2:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - 1'b1;
            dbusy_ff <= (dcnt_ff != 7'd1);
         end
         if (cmd.rdiv_start) begin
            rq_ff <= rate_ok_ff ? rnum_ff : '0;
            rrem_ff <= '0;
            rcnt_ff <= 5'd26;
            rbusy_ff <= rate_ok_ff;
         end else if (rbusy_ff) begin
            if (rrem_sh >= {1'b0, dt_ff}) begin
               rrem_ff <= rrem_sh - {1'b0, dt_ff};
               rq_ff <= {rq_ff[24:0], 1'b1};
            end else begin
               rrem_ff <= rrem_sh;
               rq_ff <= {rq_ff[24:0], 1'b0};
            end
            rcnt_ff <= rcnt_ff - 1'b1;
            rbusy_ff <= (rcnt_ff != 5'd1);
         end
         if (cmd.sqrt_start) begin
            sv_ff <= q_ff[31:0];
            root_ff <= '0;
            srem_ff <= '0;
            scnt_ff <= 5'd16;
            sbusy_ff <= 1'b1;
         end else if (sbusy_ff) begin
            sv_ff <= {sv_ff[29:0], 2'b00};
            if (srem_sh >= strial) begin
               srem_ff <= srem_sh - strial;
               root_ff <= {root_ff[14:0], 1'b1};
            end else begin
               srem_ff <= srem_sh;
               root_ff <= {root_ff[14:0], 1'b0};
            end
            scnt_ff <= scnt_ff - 1'b1;
            sbusy_ff <= (scnt_ff != 5'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         distance_out <= d_ff;
         timestamp_out <= t_ff;
         variance <= q_ff[30:0];
         jitter <= root_ff;
         rate_out <= rq_ff;
      end
   end
endmodule

[src/swsf_control.sv]
`timescale 1ns / 1ps
module swsf_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_fire,
   input  logic                   rsp_tready,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   output swsf_pkg::swsf_cmd_type cmd,
   input  swsf_pkg::swsf_sts_type sts
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_UPD = 3'd1;
   localparam logic [2:0] ST_NUM = 3'd2;
   localparam logic [2:0] ST_SQ = 3'd3;
   localparam logic [2:0] ST_DIV = 3'd4;
   localparam logic [2:0] ST_ROOT = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic out_ff, out_in;
   logic dwait_ff, dwait_in;

   assign rsp_tvalid = out_ff;
   // The output register frees the core once the result is loaded.
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      out_in = out_ff && !rsp_tready;
      dwait_in = dwait_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            cmd.mul_num = 1'b1;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.mul_sq = 1'b1;
            state_in = ST_DIV;
            dwait_in = 1'b0;
         end
         ST_DIV: begin
            if (!dwait_ff) begin
               cmd.div_start = 1'b1;
               cmd.rdiv_start = 1'b1;
               dwait_in = 1'b1;
            end else if (sts.div_done) begin
               cmd.sqrt_start = 1'b1;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (sts.sqrt_done)
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               out_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_ff <= 1'b0;
         dwait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff <= out_in;
         dwait_ff <= dwait_in;
      end
   end
endmodule

[src/sliding_window_stats_features.sv]
`timescale 1ns / 1ps
// An accepted sample goes through load, update, sums and n*S2 - S1^2, then the
// 44-step variance divider (the 26-step rate divider runs beside it), then the
// 16-step root. A new sample is taken only after the result register loads.
// A result waiting in the output register does not block the next sample.
// Reset (synchronous, active high) empties the window and previous sample.
module sliding_window_stats_features (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,  // distance[15:0], timestamp[47:16]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata   // distance_out, timestamp_out, variance,
                                    // jitter, rate, zero pad
);
   swsf_pkg::swsf_cmd_type cmd;
   swsf_pkg::swsf_sts_type sts;
   logic [15:0] d_o;
   logic [31:0] t_o;
   logic [30:0] var_o;
   logic [15:0] jit_o;
   logic [25:0] rate_o;

   swsf_control u_ctrl (
      .clock(clock), .reset(reset),
      .req_fire(req_tvalid && req_tready), .rsp_tready(rsp_tready),
      .req_tready(req_tready), .rsp_tvalid(rsp_tvalid), .cmd(cmd), .sts(sts)
   );

   swsf_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .distance(req_tdata[15:0]), .timestamp(req_tdata[47:16]),
      .distance_out(d_o), .timestamp_out(t_o), .variance(var_o),
      .jitter(jit_o), .rate_out(rate_o)
   );

   assign rsp_tdata = {7'd0, rate_o, jit_o, var_o, t_o, d_o};
endmodule

[src/swsf_checker.sv]
`timescale 1ns / 1ps
module swsf_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[127:121] == 7'd0)
      else $error("pad bits not zero");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second sample accepted while busy");
   a_jit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[78:48] == 31'd0 |-> rsp_tdata[94:79] == 16'd0)
      else $error("nonzero jitter with zero variance");
endmodule

bind sliding_window_stats_features swsf_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
